FILE: src/rlsf_pkg.sv
// Shared types and constants for the reflector link session controller.
package rlsf_pkg;

    typedef enum logic [2:0] {
        PH_DISC      = 3'd0,
        PH_LOOKUP    = 3'd1,
        PH_LPEND     = 3'd2,
        PH_CONNREQ   = 3'd3,
        PH_CONNECTED = 3'd4,
        PH_DISCREQ   = 3'd5,
        PH_DISCSENT  = 3'd6,
        PH_WAIT      = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_PACKET = 3'd1,
        CMD_START  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_INFO   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_KEEPALIVE_TICKS = 3'd0,
        CFG_REQUEST_TICKS   = 3'd1,
        CFG_REQUEST_TRIES   = 3'd2,
        CFG_LOOKUP_TICKS    = 3'd3,
        CFG_LOOKUP_TRIES    = 3'd4,
        CFG_FAILURE_TICKS   = 3'd5,
        CFG_MODULE_CHAR     = 3'd6
    } t_cfg_idx;

    localparam logic [7:0]  LOST_BACKOFF = 8'd2;
    localparam logic [10:0] SHORT_LEN    = 11'd14;
    localparam logic [10:0] KEEP_LEN     = 11'd25;
    localparam logic [23:0] ACK_WORD     = 24'h41434B;
    localparam logic [7:0]  SPACE_CHAR   = 8'h20;

    localparam logic [7:0] RST_KEEPALIVE_TICKS = 8'd100;
    localparam logic [7:0] RST_REQUEST_TICKS   = 8'd6;
    localparam logic [7:0] RST_REQUEST_TRIES   = 8'd3;
    localparam logic [7:0] RST_LOOKUP_TICKS    = 8'd2;
    localparam logic [7:0] RST_LOOKUP_TRIES    = 8'd15;
    localparam logic [7:0] RST_FAILURE_TICKS   = 8'd30;
    localparam logic [7:0] RST_MODULE_CHAR     = 8'd32;

    typedef struct packed {
        logic [7:0] keepalive_ticks;
        logic [7:0] request_ticks;
        logic [7:0] request_tries;
        logic [7:0] lookup_ticks;
        logic [7:0] lookup_tries;
        logic [7:0] failure_ticks;
        logic [7:0] module_char;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  countdown;
        logic [7:0]  tries_left;
        logic [31:0] server_addr;
        logic        info_waiting;
        logic        port_active;
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        resolver_accepts;
        logic        lookup_ready;
        logic        lookup_ok;
        logic [31:0] lookup_addr;
        logic        reflector_ok;
        logic [31:0] src_addr;
        logic [10:0] pkt_len;
        logic [7:0]  byte_eight;
        logic [7:0]  byte_nine;
        logic [23:0] ack_bytes;
    } t_item;

    typedef struct packed {
        logic       send_connect;
        logic       send_disconnect;
        logic       send_keepalive;
        logic       send_info;
        logic       lookup_request;
        logic       lookup_release;
        logic       port_open;
        logic       session_up;
        logic [2:0] session_state;
    } t_result;

endpackage

FILE: src/rlsf_cfg.sv
// Configuration register file for timing, retry and module settings.
module rlsf_cfg import rlsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  logic [2:0] i_index,
    input  logic [7:0] i_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_KEEPALIVE_TICKS: n_cfg.keepalive_ticks = i_data;
                CFG_REQUEST_TICKS:   n_cfg.request_ticks   = i_data;
                CFG_REQUEST_TRIES:   n_cfg.request_tries   = i_data;
                CFG_LOOKUP_TICKS:    n_cfg.lookup_ticks    = i_data;
                CFG_LOOKUP_TRIES:    n_cfg.lookup_tries    = i_data;
                CFG_FAILURE_TICKS:   n_cfg.failure_ticks   = i_data;
                CFG_MODULE_CHAR:     n_cfg.module_char     = i_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keepalive_ticks <= RST_KEEPALIVE_TICKS;
            r_cfg.request_ticks   <= RST_REQUEST_TICKS;
            r_cfg.request_tries   <= RST_REQUEST_TRIES;
            r_cfg.lookup_ticks    <= RST_LOOKUP_TICKS;
            r_cfg.lookup_tries    <= RST_LOOKUP_TRIES;
            r_cfg.failure_ticks   <= RST_FAILURE_TICKS;
            r_cfg.module_char     <= RST_MODULE_CHAR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/rlsf_core.sv
// Next-state and result logic of the session machine for one request.
module rlsf_core import rlsf_pkg::*; (
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_state     n_st;
    t_result    res;
    logic [7:0] cd_dec;
    logic [7:0] tl_dec;

    always_comb begin
        n_st   = i_state;
        res    = '0;
        // timer and retry counter saturate at zero
        cd_dec = (i_state.countdown != 8'd0) ? i_state.countdown - 8'd1 : 8'd0;
        tl_dec = (i_state.tries_left != 8'd0) ? i_state.tries_left - 8'd1 : 8'd0;

        case (t_cmd'(i_item.cmd))
            CMD_TICK: begin
                n_st.countdown = cd_dec;
                case (i_state.phase)
                    PH_CONNECTED: begin
                        if (cd_dec == 8'd0) begin
                            n_st.countdown   = LOST_BACKOFF;
                            n_st.phase       = PH_WAIT;
                            n_st.port_active = 1'b0;
                        end else if (i_state.info_waiting) begin
                            res.send_info     = 1'b1;
                            n_st.info_waiting = 1'b0;
                        end
                    end
                    PH_CONNREQ: begin
                        if (cd_dec == 8'd0) begin
                            n_st.tries_left = tl_dec;
                            if (tl_dec == 8'd0) begin
                                n_st.countdown   = i_cfg.failure_ticks;
                                n_st.phase       = PH_WAIT;
                                n_st.port_active = 1'b0;
                            end else begin
                                res.send_connect = 1'b1;
                                n_st.countdown   = i_cfg.request_ticks;
                            end
                        end
                    end
                    PH_DISCREQ: begin
                        res.send_disconnect = 1'b1;
                        n_st.countdown      = i_cfg.request_ticks;
                        n_st.phase          = PH_DISCSENT;
                        n_st.tries_left     = i_cfg.request_tries;
                    end
                    PH_DISCSENT: begin
                        if (cd_dec == 8'd0) begin
                            n_st.tries_left = tl_dec;
                            if (tl_dec == 8'd0) begin
                                n_st.phase       = PH_DISC;
                                n_st.port_active = 1'b0;
                            end else begin
                                res.send_disconnect = 1'b1;
                                n_st.countdown      = i_cfg.request_ticks;
                            end
                        end
                    end
                    PH_LOOKUP: begin
                        res.lookup_request = 1'b1;
                        if (i_item.resolver_accepts) begin
                            n_st.phase = PH_LPEND;
                        end else if (cd_dec == 8'd0) begin
                            n_st.tries_left = tl_dec;
                            if (tl_dec == 8'd0) begin
                                n_st.countdown = i_cfg.failure_ticks;
                                n_st.phase     = PH_WAIT;
                            end else begin
                                n_st.countdown = i_cfg.lookup_ticks;
                            end
                        end
                    end
                    PH_LPEND: begin
                        if (i_item.lookup_ready) begin
                            if (!i_item.lookup_ok) begin
                                n_st.countdown = i_cfg.failure_ticks;
                                n_st.phase     = PH_WAIT;
                            end else begin
                                n_st.server_addr = i_item.lookup_addr;
                                n_st.port_active = 1'b1;
                                res.send_connect = 1'b1;
                                n_st.phase       = PH_CONNREQ;
                                n_st.tries_left  = i_cfg.request_tries;
                                n_st.countdown   = i_cfg.request_ticks;
                            end
                            res.lookup_release = 1'b1;
                        end
                    end
                    PH_WAIT: begin
                        if (cd_dec == 8'd0) begin
                            n_st.tries_left = i_cfg.lookup_tries;
                            n_st.countdown  = i_cfg.lookup_ticks;
                            n_st.phase      = PH_LOOKUP;
                        end
                    end
                    default: begin
                        n_st.countdown = cd_dec;
                    end
                endcase
            end
            CMD_PACKET: begin
                if (i_item.src_addr == i_state.server_addr) begin
                    if (i_item.pkt_len == SHORT_LEN) begin
                        if (i_state.phase == PH_CONNREQ) begin
                            if (i_item.byte_eight == i_cfg.module_char &&
                                i_item.ack_bytes == ACK_WORD) begin
                                n_st.info_waiting = 1'b0;
                                n_st.phase        = PH_CONNECTED;
                                n_st.countdown    = i_cfg.keepalive_ticks;
                            end else begin
                                n_st.phase       = PH_DISC;
                                n_st.port_active = 1'b0;
                            end
                        end else if (i_state.phase == PH_DISCSENT &&
                                     i_item.byte_nine == SPACE_CHAR) begin
                            n_st.phase       = PH_DISC;
                            n_st.port_active = 1'b0;
                        end
                    end else if (i_item.pkt_len == KEEP_LEN &&
                                 i_state.phase == PH_CONNECTED) begin
                        n_st.countdown     = i_cfg.keepalive_ticks;
                        res.send_keepalive = 1'b1;
                    end
                end
            end
            CMD_START: begin
                if (i_state.phase == PH_DISC && i_item.reflector_ok) begin
                    n_st.phase = PH_LOOKUP;
                end
            end
            CMD_STOP: begin
                if (i_state.phase == PH_CONNECTED) begin
                    n_st.phase = PH_DISCREQ;
                end else begin
                    n_st.port_active = 1'b0;
                    n_st.phase       = PH_DISC;
                end
            end
            CMD_INFO: begin
                if (i_state.phase == PH_CONNECTED || i_state.phase == PH_DISCSENT) begin
                    n_st.info_waiting = 1'b1;
                end
            end
            default: begin
                n_st = i_state;
            end
        endcase

        res.port_open     = n_st.port_active;
        res.session_up    = (n_st.phase == PH_CONNECTED) || (n_st.phase == PH_DISCSENT);
        res.session_state = n_st.phase;
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

FILE: src/reflector_link_session_fsm.sv
// Top level of the reflector link session controller.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+--------------------------------
//  request  | i_in_valid   | o_in_ready   | i_cmd .. i_ack_bytes
//  result   | o_out_valid  | i_out_ready  | o_send_connect .. o_session_state
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request per cycle sustained unless the result stalls; input register,
// then the session state update and result register in the same edge.
// Session state advances only when a request moves into the result register,
// so the next request always sees the updated state.
// A stalled result holds both stages; the input register frees as soon as the
// result side moves. Reset is synchronous; config is always ready.
module reflector_link_session_fsm import rlsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic        i_resolver_accepts,
    input  logic        i_lookup_ready,
    input  logic        i_lookup_ok,
    input  logic [31:0] i_lookup_addr,
    input  logic        i_reflector_ok,
    input  logic [31:0] i_src_addr,
    input  logic [10:0] i_pkt_len,
    input  logic [7:0]  i_byte_eight,
    input  logic [7:0]  i_byte_nine,
    input  logic [23:0] i_ack_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_connect,
    output logic        o_send_disconnect,
    output logic        o_send_keepalive,
    output logic        o_send_info,
    output logic        o_lookup_request,
    output logic        o_lookup_release,
    output logic        o_port_open,
    output logic        o_session_up,
    output logic [2:0]  o_session_state,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    logic    r_item_valid;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    advance;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;

    rlsf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    rlsf_core u_core (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // result register free or being drained
    assign advance    = r_item_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_item_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.cmd              <= i_cmd;
            r_item.resolver_accepts <= i_resolver_accepts;
            r_item.lookup_ready     <= i_lookup_ready;
            r_item.lookup_ok        <= i_lookup_ok;
            r_item.lookup_addr      <= i_lookup_addr;
            r_item.reflector_ok     <= i_reflector_ok;
            r_item.src_addr         <= i_src_addr;
            r_item.pkt_len          <= i_pkt_len;
            r_item.byte_eight       <= i_byte_eight;
            r_item.byte_nine        <= i_byte_nine;
            r_item.ack_bytes        <= i_ack_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_DISC;
            r_state.countdown    <= 8'd0;
            r_state.tries_left   <= 8'd0;
            r_state.server_addr  <= 32'd0;
            r_state.info_waiting <= 1'b0;
            r_state.port_active  <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_send_connect    = r_result.send_connect;
    assign o_send_disconnect = r_result.send_disconnect;
    assign o_send_keepalive  = r_result.send_keepalive;
    assign o_send_info       = r_result.send_info;
    assign o_lookup_request  = r_result.lookup_request;
    assign o_lookup_release  = r_result.lookup_release;
    assign o_port_open       = r_result.port_open;
    assign o_session_up      = r_result.session_up;
    assign o_session_state   = r_result.session_state;

endmodule
